// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies; take in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/cdcb_pkg.sv =====
// Types, codes and response byte tables of the changer bus responder.
// No dependencies.
package cdcb_pkg;

    // request kinds on the input channel
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // result kinds
    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    // body commands
    localparam logic [7:0] BODY_PLAY   = 8'h06;
    localparam logic [7:0] BODY_STOP   = 8'h16;
    localparam logic [7:0] BODY_NEXT   = 8'h26;
    localparam logic [7:0] BODY_PREV   = 8'h27;
    localparam logic [7:0] BODY_RANDOM = 8'h28;
    localparam logic [7:0] BODY_DISC1  = 8'h31;
    localparam logic [7:0] BODY_DISC2  = 8'h32;
    localparam logic [7:0] BODY_DISC3  = 8'h33;
    localparam logic [7:0] BODY_DISC4  = 8'h34;
    localparam logic [7:0] BODY_DISC5  = 8'h35;
    localparam logic [7:0] BODY_DISC6  = 8'h36;
    localparam logic [7:0] BODY_NOP0   = 8'h00;
    localparam logic [7:0] BODY_NOP1   = 8'hF0;
    localparam logic [7:0] BODY_NOP2   = 8'hF6;
    localparam logic [7:0] BODY_POLL   = 8'hFF;

    localparam logic [7:0] MINUTE_LIMIT = 8'd60;
    localparam logic [7:0] OWN_ADDR_RST = 8'h06;

    // response bytes
    localparam logic [7:0] HDR_SHORT  = 8'h60;
    localparam logic [7:0] HDR_LONG   = 8'h61;
    localparam logic [7:0] LEN_ACK    = 8'h01;
    localparam logic [7:0] LEN_IDLE   = 8'h03;
    localparam logic [7:0] LEN_PLAY   = 8'h0A;
    localparam logic [7:0] DEV_ID     = 8'h18;
    localparam logic [7:0] PLAY_MODE  = 8'h04;
    localparam logic [7:0] PLAY_TAG   = 8'hF1;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [7:0] PAD_FILL   = 8'h3F;
    localparam logic [7:0] STAT_RECOV = 8'h10;
    localparam logic [7:0] STAT_NORM  = 8'h11;
    localparam logic [7:0] IDLE_TAIL  = 8'h01;

    typedef enum logic [2:0] {
        PH_ADDR     = 3'd0,
        PH_SKIPLEN  = 3'd1,
        PH_SKIPPING = 3'd2,
        PH_OWNLEN   = 3'd3,
        PH_BODY     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MSG_NONE = 2'd0,
        MSG_ACK  = 2'd1,
        MSG_PLAY = 2'd2,
        MSG_IDLE = 2'd3
    } msg_kind_t;

    // one pending response: optional error notice, then a message
    typedef struct packed {
        msg_kind_t  kind;
        logic       err;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] track;
        logic       rec;
    } resp_desc_t;

    function automatic logic [3:0] msg_len(msg_kind_t k);
        logic [3:0] n;
        n = 4'd0;
        case (k)
            MSG_ACK:  n = 4'd3;
            MSG_PLAY: n = 4'd12;
            MSG_IDLE: n = 4'd5;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] msg_byte(resp_desc_t d, logic [3:0] j);
        logic [7:0] b;
        b = PAD_ZERO;
        case (d.kind)
            MSG_ACK:
                case (j)
                    4'd0:    b = HDR_SHORT;
                    4'd1:    b = LEN_ACK;
                    default: b = DEV_ID;
                endcase
            MSG_PLAY:
                case (j)
                    4'd0:    b = HDR_LONG;
                    4'd1:    b = LEN_PLAY;
                    4'd2:    b = DEV_ID;
                    4'd3:    b = PLAY_MODE;
                    4'd4:    b = PLAY_TAG;
                    4'd5:    b = d.minutes;
                    4'd6:    b = d.seconds;
                    4'd7:    b = d.track;
                    4'd9:    b = PAD_FILL;
                    4'd10:   b = PAD_FILL;
                    default: b = PAD_ZERO;
                endcase
            MSG_IDLE:
                case (j)
                    4'd0:    b = HDR_SHORT;
                    4'd1:    b = LEN_IDLE;
                    4'd2:    b = DEV_ID;
                    4'd3:    b = d.rec ? STAT_RECOV : STAT_NORM;
                    default: b = IDLE_TAIL;
                endcase
            default: b = PAD_ZERO;
        endcase
        return b;
    endfunction

endpackage

// ===== src/cd_changer_bus_responder_core.sv =====
// Top level of the changer bus responder: input register, parser, emitter.
// Depends on cdcb_pkg, cdcb_parser and cdcb_emitter.
//
// Usage:
//  - Input channel (in_valid/in_ready, req_type, rx_byte): one transfer per
//    received bus byte, seconds tick or reset-line event.
//  - Output channel (out_valid/out_ready, result_kind, tx_byte, last_of_run):
//    zero to 13 results per input; last_of_run marks the final one.
//  - cfg_we/cfg_wdata write own_address (reset 0x06); write only when idle.
//  - Path: the first result of an input passes the input register, the
//    emitter's descriptor register and then the output register.
//  - Flow: an input with no results leaves without using the emitter. An
//    input with N results loads the emitter once, then it sends one result
//    per cycle while the receiver takes them. The emitter holds one
//    response, so the next input with results waits for it.
//  - While a response is being sent, inputs that cause no results (ticks,
//    skipped bytes) keep flowing.
//  - Reset: parser returns to address hunting, all counters and flags clear,
//    nothing pending on the output.
//  - Receiver stall: the output register holds its result; the emitter stops,
//    then the input register fills and in_ready drops.
module cd_changer_bus_responder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] tx_byte,
    output logic       last_of_run,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    // input register
    logic       in_valid_reg;
    logic [1:0] in_type_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] own_addr_reg;

    logic                 has_result;
    logic                 desc_ready;
    logic                 advance;
    cdcb_pkg::resp_desc_t desc;

    // item leaves the input register once its response (if any) has a home
    assign advance  = in_valid_reg && (!has_result || desc_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            own_addr_reg <= cdcb_pkg::OWN_ADDR_RST;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                own_addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_type_reg <= req_type;
            in_byte_reg <= rx_byte;
        end
    end

    cdcb_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item_type   (in_type_reg),
        .item_byte   (in_byte_reg),
        .own_address (own_addr_reg),
        .advance     (advance),
        .has_result  (has_result),
        .desc        (desc)
    );

    cdcb_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_load   (advance && has_result),
        .desc        (desc),
        .desc_ready  (desc_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_byte     (tx_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ===== src/cdcb_parser.sv =====
// Message parser and changer state: turns one registered input item into
// state updates and a response descriptor. Depends on cdcb_pkg.
module cdcb_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           item_type,
    input  logic [7:0]           item_byte,
    input  logic [7:0]           own_address,
    input  logic                 advance,
    output logic                 has_result,
    output cdcb_pkg::resp_desc_t desc
);

    cdcb_pkg::phase_t phase_reg, phase_next;
    logic [7:0] skip_reg, skip_next;
    logic       play_reg, play_next;
    logic       rand_reg, rand_next;
    logic       rec_reg, rec_next;
    logic [7:0] track_reg, track_next;
    logic [3:0] disc_reg, disc_next;
    logic [7:0] sec_reg, sec_next;
    logic [7:0] min_reg, min_next;

    always_comb
    begin
        logic [7:0] skip_dec;
        logic       status;
        skip_dec   = skip_reg - 8'd1;
        status     = 1'b0;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        play_next  = play_reg;
        rand_next  = rand_reg;
        rec_next   = rec_reg;
        track_next = track_reg;
        disc_next  = disc_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        desc.kind    = cdcb_pkg::MSG_NONE;
        desc.err     = 1'b0;
        desc.minutes = min_reg;
        desc.seconds = sec_reg;
        desc.track   = track_reg;
        desc.rec     = rec_reg;
        if (item_valid)
        begin
            case (item_type)
                cdcb_pkg::REQ_BYTE:
                    unique case (phase_reg)
                        cdcb_pkg::PH_ADDR:
                            phase_next = (item_byte == own_address) ?
                                         cdcb_pkg::PH_OWNLEN : cdcb_pkg::PH_SKIPLEN;
                        cdcb_pkg::PH_SKIPLEN:
                            if (item_byte == 8'd0)
                            begin
                                phase_next = cdcb_pkg::PH_ADDR;
                            end
                            else
                            begin
                                skip_next  = item_byte;
                                phase_next = cdcb_pkg::PH_SKIPPING;
                            end
                        cdcb_pkg::PH_SKIPPING:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                phase_next = cdcb_pkg::PH_ADDR;
                            end
                        end
                        cdcb_pkg::PH_OWNLEN:
                            if (item_byte > 8'd1)
                            begin
                                desc.err   = 1'b1;
                                phase_next = cdcb_pkg::PH_ADDR;
                            end
                            else if (item_byte == 8'd0)
                            begin
                                desc.kind  = cdcb_pkg::MSG_ACK;
                                phase_next = cdcb_pkg::PH_ADDR;
                            end
                            else
                            begin
                                phase_next = cdcb_pkg::PH_BODY;
                            end
                        cdcb_pkg::PH_BODY:
                        begin
                            phase_next = cdcb_pkg::PH_ADDR;
                            status     = 1'b1;
                            unique case (item_byte) inside
                                cdcb_pkg::BODY_PLAY:   play_next  = 1'b1;
                                cdcb_pkg::BODY_STOP:   play_next  = 1'b0;
                                cdcb_pkg::BODY_NEXT:   track_next = track_reg + 8'd1;
                                cdcb_pkg::BODY_PREV:   track_next = track_reg - 8'd1;
                                cdcb_pkg::BODY_RANDOM: rand_next  = ~rand_reg;
                                cdcb_pkg::BODY_DISC1, cdcb_pkg::BODY_DISC2,
                                cdcb_pkg::BODY_DISC3, cdcb_pkg::BODY_DISC4,
                                cdcb_pkg::BODY_DISC5, cdcb_pkg::BODY_DISC6:
                                    disc_next = item_byte[3:0];
                                cdcb_pkg::BODY_POLL:
                                begin
                                    status    = 1'b0;
                                    desc.kind = cdcb_pkg::MSG_ACK;
                                end
                                cdcb_pkg::BODY_NOP0, cdcb_pkg::BODY_NOP1,
                                cdcb_pkg::BODY_NOP2: ;
                                default: desc.err = 1'b1;
                            endcase
                        end
                        default: phase_next = cdcb_pkg::PH_ADDR;
                    endcase
                cdcb_pkg::REQ_TICK:  sec_next = sec_reg + 8'd1;
                cdcb_pkg::REQ_RESET: rec_next = 1'b1;
                default: ;
            endcase
        end
        // status reply reflects the state after the body command
        if (status)
        begin
            desc.track = track_next;
            if (play_next)
            begin
                desc.kind = cdcb_pkg::MSG_PLAY;
                if (sec_reg > cdcb_pkg::MINUTE_LIMIT)
                begin
                    min_next = min_reg + 8'd1;
                    sec_next = 8'd0;
                end
                desc.minutes = min_next;
                desc.seconds = sec_next;
            end
            else
            begin
                desc.kind = cdcb_pkg::MSG_IDLE;
                desc.rec  = rec_reg;
                rec_next  = 1'b0;
            end
        end
    end

    assign has_result = desc.err || (desc.kind != cdcb_pkg::MSG_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cdcb_pkg::PH_ADDR;
            skip_reg  <= 8'd0;
            play_reg  <= 1'b0;
            rand_reg  <= 1'b0;
            rec_reg   <= 1'b0;
            track_reg <= 8'd0;
            disc_reg  <= 4'd0;
            sec_reg   <= 8'd0;
            min_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            play_reg  <= play_next;
            rand_reg  <= rand_next;
            rec_reg   <= rec_next;
            track_reg <= track_next;
            disc_reg  <= disc_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
        end
    end

endmodule

// ===== src/cdcb_emitter.sv =====
// Response serializer: walks one descriptor and drives result items through
// an output register. Depends on cdcb_pkg.
module cdcb_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 desc_load,
    input  cdcb_pkg::resp_desc_t desc,
    output logic                 desc_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [7:0]           tx_byte,
    output logic                 last_of_run
);

    cdcb_pkg::resp_desc_t desc_reg;
    logic [3:0] idx_reg;
    logic       busy_reg;
    logic       out_valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       err_slot;
    logic [3:0] j;
    logic [3:0] len;
    logic       cur_last;
    logic       step;

    assign err_slot = desc_reg.err && (idx_reg == 4'd0);
    assign j        = idx_reg - {3'd0, desc_reg.err};
    assign len      = cdcb_pkg::msg_len(desc_reg.kind);
    assign cur_last = err_slot ? (len == 4'd0) : (j == len - 4'd1);
    assign step     = busy_reg && (!out_valid_reg || out_ready);

    assign desc_ready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 4'd1;
                if (cur_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (!busy_reg && desc_load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && desc_load)
        begin
            desc_reg <= desc;
        end
        if (step)
        begin
            kind_reg <= err_slot ? cdcb_pkg::KIND_ERR : cdcb_pkg::KIND_TX;
            byte_reg <= err_slot ? 8'd0 : cdcb_pkg::msg_byte(desc_reg, j);
            last_reg <= cur_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign tx_byte     = byte_reg;
    assign last_of_run = last_reg;

endmodule

// ===== src/cdcb_checker.sv =====
// Port-level checks of the changer bus responder, bound to the top level.
// Depends on assert_macros.svh and cdcb_pkg.
`include "assert_macros.svh"

module cdcb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       result_kind,
    input logic [7:0] tx_byte,
    input logic       last_of_run
);

    // an error notice carries no byte
    `ASSERT_IMPL(a_err_no_byte, clk, rst_n,
        out_valid && (result_kind == cdcb_pkg::KIND_ERR), tx_byte == 8'd0)

    // a response run continues without gaps once its first transfer is taken
    `ASSERT_NEXT(a_run_no_gap, clk, rst_n,
        out_valid && out_ready && !last_of_run, out_valid)

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(tx_byte) && $stable(result_kind) && $stable(last_of_run))

endmodule

bind cd_changer_bus_responder_core cdcb_checker u_cdcb_checker (.*);

// ===== tb/sv/tb_cd_changer_bus_responder_core.sv =====
// Self-checking testbench for cd_changer_bus_responder_core.
// Drives bus bytes, ticks and reset-line events and checks every response result.
// Depends on cdcb_pkg and the RTL of the responder.
module tb_cd_changer_bus_responder_core;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [7:0] OTHER_ADDR = cdcb_pkg::OWN_ADDR_RST + 8'd1;

    // The longest correct stretch without any transfer is the forced receiver
    // hold-off (HOLD_CYCLES) plus the random gaps around it; the idle pauses
    // around config writes are shorter still.
    localparam int HOLD_CYCLES    = 100;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
    } bus_input_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } bus_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = cdcb_pkg::REQ_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    // items waiting to be offered, and response results waiting to arrive
    bus_input_t  bus_inputs[$];
    bus_result_t tx_expected[$];
    bus_result_t burst[$];
    bus_input_t  cur_input;

    // private copy of the responder state
    logic [7:0]       own_addr = cdcb_pkg::OWN_ADDR_RST;
    cdcb_pkg::phase_t parse_ph = cdcb_pkg::PH_ADDR;
    logic [7:0]       skip_left = 8'h00;
    logic             playing = 1'b0;
    logic             shuffle = 1'b0;
    logic             recovery = 1'b0;
    logic [7:0]       track = 8'h00;
    logic [3:0]       disc = 4'h0;
    logic [7:0]       secs = 8'h00;
    logic [7:0]       mins = 8'h00;

    logic [7:0] known_bodies[15] = '{cdcb_pkg::BODY_PLAY, cdcb_pkg::BODY_STOP,
        cdcb_pkg::BODY_NEXT, cdcb_pkg::BODY_PREV, cdcb_pkg::BODY_RANDOM,
        cdcb_pkg::BODY_DISC1, cdcb_pkg::BODY_DISC2, cdcb_pkg::BODY_DISC3,
        cdcb_pkg::BODY_DISC4, cdcb_pkg::BODY_DISC5, cdcb_pkg::BODY_DISC6,
        cdcb_pkg::BODY_NOP0, cdcb_pkg::BODY_NOP1, cdcb_pkg::BODY_NOP2,
        cdcb_pkg::BODY_NOP0};

    // traffic shaping
    bit calm = 1'b0;          // no idling on either side once set
    bit hold_request = 1'b0;  // asks the receiver for one long hold-off
    int hold_left = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;
    int n_fail = 0;

    cd_changer_bus_responder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_byte     (tx_byte),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    //--------------------------------------------------------------------
    // Response prediction
    //--------------------------------------------------------------------
    task automatic emit(input logic k, input logic [7:0] v);
        bus_result_t r;
        r.kind = k;
        r.data = v;
        r.last = 1'b0;
        burst.push_back(r);
    endtask

    // 60 01 18
    task automatic emit_ack();
        emit(cdcb_pkg::KIND_TX, cdcb_pkg::HDR_SHORT);
        emit(cdcb_pkg::KIND_TX, cdcb_pkg::LEN_ACK);
        emit(cdcb_pkg::KIND_TX, cdcb_pkg::DEV_ID);
    endtask

    task automatic predict_response(input logic [1:0] req, input logic [7:0] b);
        burst.delete();
        case (req)
            cdcb_pkg::REQ_TICK:  secs = secs + 8'd1;
            cdcb_pkg::REQ_RESET: recovery = 1'b1;
            cdcb_pkg::REQ_BYTE:
            begin
                case (parse_ph)
                    cdcb_pkg::PH_ADDR:
                        parse_ph = (b == own_addr) ? cdcb_pkg::PH_OWNLEN
                                                   : cdcb_pkg::PH_SKIPLEN;
                    cdcb_pkg::PH_SKIPLEN:
                    begin
                        if (b == 8'h00)
                            parse_ph = cdcb_pkg::PH_ADDR;
                        else
                        begin
                            skip_left = b;
                            parse_ph = cdcb_pkg::PH_SKIPPING;
                        end
                    end
                    cdcb_pkg::PH_SKIPPING:
                    begin
                        skip_left = skip_left - 8'd1;
                        if (skip_left == 8'h00)
                            parse_ph = cdcb_pkg::PH_ADDR;
                    end
                    cdcb_pkg::PH_OWNLEN:
                    begin
                        parse_ph = cdcb_pkg::PH_ADDR;
                        if (b > 8'd1)
                            emit(cdcb_pkg::KIND_ERR, 8'h00);
                        else if (b == 8'd0)
                            emit_ack();
                        else
                            parse_ph = cdcb_pkg::PH_BODY;
                    end
                    cdcb_pkg::PH_BODY:
                    begin
                        parse_ph = cdcb_pkg::PH_ADDR;
                        if (b == cdcb_pkg::BODY_POLL)
                            emit_ack();
                        else
                        begin
                            case (b)
                                cdcb_pkg::BODY_PLAY:   playing = 1'b1;
                                cdcb_pkg::BODY_STOP:   playing = 1'b0;
                                cdcb_pkg::BODY_NEXT:   track = track + 8'd1;
                                cdcb_pkg::BODY_PREV:   track = track - 8'd1;
                                cdcb_pkg::BODY_RANDOM: shuffle = ~shuffle;
                                cdcb_pkg::BODY_DISC1, cdcb_pkg::BODY_DISC2,
                                cdcb_pkg::BODY_DISC3, cdcb_pkg::BODY_DISC4,
                                cdcb_pkg::BODY_DISC5, cdcb_pkg::BODY_DISC6:
                                    disc = b[3:0];
                                cdcb_pkg::BODY_NOP0, cdcb_pkg::BODY_NOP1,
                                cdcb_pkg::BODY_NOP2: ;
                                default: emit(cdcb_pkg::KIND_ERR, 8'h00);
                            endcase
                            if (playing)
                            begin
                                // minute rolls over when the status is built
                                if (secs > cdcb_pkg::MINUTE_LIMIT)
                                begin
                                    mins = mins + 8'd1;
                                    secs = 8'h00;
                                end
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::HDR_LONG);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::LEN_PLAY);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::DEV_ID);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::PLAY_MODE);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::PLAY_TAG);
                                emit(cdcb_pkg::KIND_TX, mins);
                                emit(cdcb_pkg::KIND_TX, secs);
                                emit(cdcb_pkg::KIND_TX, track);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::PAD_ZERO);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::PAD_FILL);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::PAD_FILL);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::PAD_ZERO);
                            end
                            else
                            begin
                                // not playing: reports and clears recovery
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::HDR_SHORT);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::LEN_IDLE);
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::DEV_ID);
                                emit(cdcb_pkg::KIND_TX, recovery ? cdcb_pkg::STAT_RECOV
                                                                 : cdcb_pkg::STAT_NORM);
                                recovery = 1'b0;
                                emit(cdcb_pkg::KIND_TX, cdcb_pkg::IDLE_TAIL);
                            end
                        end
                    end
                    default: parse_ph = cdcb_pkg::PH_ADDR;
                endcase
            end
            default: ;  // unused request type: no effect
        endcase
        if (burst.size() != 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            tx_expected.push_back(burst[i]);
    endtask

    //--------------------------------------------------------------------
    // Input driver: one transfer per accepted item, random gaps
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                predict_response(req_type, rx_byte);
            // a new item may go out only when the current one has moved
            if (!in_valid || in_ready)
            begin
                if (send_gap == 0 && !calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 7);
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (bus_inputs.size() != 0)
                begin
                    cur_input = bus_inputs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_input.req;
                    rx_byte  <= cur_input.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------
    // Output monitor: checks each transfer and throttles out_ready
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tx_expected.size() == 0)
                begin
                    $error("unexpected result: result_kind %0d tx_byte %02h last_of_run %0d",
                           result_kind, tx_byte, last_of_run);
                    n_fail++;
                end
                else
                begin
                    want = tx_expected.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        n_fail++;
                    end
                    if (tx_byte !== want.data)
                    begin
                        $error("tx_byte: expected %02h, got %02h", want.data, tx_byte);
                        n_fail++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                        n_fail++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                // long hold-off: emitter stops, input register fills
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (recv_stall == 0 && !calm && $urandom_range(0, 7) == 0)
                    recv_stall = $urandom_range(1, 7);
                if (recv_stall != 0)
                begin
                    recv_stall = recv_stall - 1;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles == WATCHDOG_LIMIT)
                begin
                    $display("FAIL cd_changer_bus_responder_core");
                    $finish;
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------
    task automatic push_item(input logic [1:0] req, input logic [7:0] v);
        bus_input_t it;
        it.req = req;
        it.data = v;
        bus_inputs.push_back(it);
    endtask

    task automatic push_own_body(input logic [7:0] body);
        push_item(cdcb_pkg::REQ_BYTE, own_addr);
        push_item(cdcb_pkg::REQ_BYTE, 8'd1);
        push_item(cdcb_pkg::REQ_BYTE, body);
    endtask

    // mostly well-formed messages with random content, some noise
    task automatic queue_random_message();
        int sel;
        int n;
        logic [7:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            n = $urandom_range(0, 9);
            if (n < 7)
                v = known_bodies[$urandom_range(0, 14)];
            else if (n < 8)
                v = cdcb_pkg::BODY_POLL;
            else
                v = 8'($urandom_range(0, 255));
            push_own_body(v);
        end
        else if (sel < 62)
        begin
            push_item(cdcb_pkg::REQ_BYTE, own_addr);
            push_item(cdcb_pkg::REQ_BYTE, 8'd0);
        end
        else if (sel < 68)
        begin
            push_item(cdcb_pkg::REQ_BYTE, own_addr);
            push_item(cdcb_pkg::REQ_BYTE, 8'($urandom_range(2, 255)));
        end
        else if (sel < 82)
        begin
            // foreign message: address differs from own in at least one bit
            n = $urandom_range(0, 5);
            push_item(cdcb_pkg::REQ_BYTE, own_addr ^ 8'($urandom_range(1, 255)));
            push_item(cdcb_pkg::REQ_BYTE, n[7:0]);
            repeat (n)
                push_item(cdcb_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
        end
        else if (sel < 92)
            repeat ($urandom_range(1, 6))
                push_item(cdcb_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
        else if (sel < 95)
            push_item(cdcb_pkg::REQ_RESET, 8'($urandom_range(0, 255)));
        else if (sel < 97)
            push_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
        else
            push_item(cdcb_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));  // stray byte
    endtask

    // wait until every item went in and every result came out, then settle
    task automatic drain();
        @(negedge clk);
        while (bus_inputs.size() != 0 || in_valid || tx_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_own_address(input logic [7:0] a);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we    <= 1'b0;
        own_addr = a;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] addr_plan[4];
        addr_plan[0] = 8'h00;
        addr_plan[1] = 8'hFF;
        addr_plan[2] = 8'($urandom_range(1, 254));
        addr_plan[3] = cdcb_pkg::OWN_ADDR_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, own address left at its reset value.
        // length zero poll, then poll body
        push_item(cdcb_pkg::REQ_BYTE, cdcb_pkg::OWN_ADDR_RST);
        push_item(cdcb_pkg::REQ_BYTE, 8'h00);
        push_own_body(cdcb_pkg::BODY_POLL);
        // own message with a length above one
        push_item(cdcb_pkg::REQ_BYTE, cdcb_pkg::OWN_ADDR_RST);
        push_item(cdcb_pkg::REQ_BYTE, 8'hFF);
        // foreign message whose skipped body looks like an own header
        push_item(cdcb_pkg::REQ_BYTE, OTHER_ADDR);
        push_item(cdcb_pkg::REQ_BYTE, 8'h02);
        push_item(cdcb_pkg::REQ_BYTE, cdcb_pkg::OWN_ADDR_RST);
        push_item(cdcb_pkg::REQ_BYTE, 8'hFF);
        // foreign message with length zero
        push_item(cdcb_pkg::REQ_BYTE, 8'h00);
        push_item(cdcb_pkg::REQ_BYTE, 8'h00);
        // reset line seen low, an ignored request, then stop reports recovery
        push_item(cdcb_pkg::REQ_RESET, 8'hFF);
        push_item(REQ_UNUSED, 8'hA5);
        push_own_body(cdcb_pkg::BODY_STOP);
        push_item(cdcb_pkg::REQ_TICK, 8'h5A);
        // playing status, track wraps below zero, unknown body
        push_own_body(cdcb_pkg::BODY_PLAY);
        push_own_body(cdcb_pkg::BODY_PREV);
        push_own_body(8'hC3);
        drain();

        // Minute rollover under a long receiver hold-off. The parser is at an
        // address byte here. The second status stays stuck behind the held
        // first one, so the input stalls; 61 ticks then push seconds past 60.
        push_own_body(cdcb_pkg::BODY_PLAY);
        push_own_body(cdcb_pkg::BODY_NOP0);
        repeat (61)
            push_item(cdcb_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
        push_own_body(cdcb_pkg::BODY_NOP0);
        hold_request = 1'b1;
        drain();

        // Random phases, each with its own address setting
        for (int p = 0; p < 4; p++)
        begin
            set_own_address(addr_plan[p]);
            repeat (2) queue_random_message();
            drain();
        end

        // closing stretch without any idling
        calm = 1'b1;
        repeat (2) queue_random_message();
        drain();

        if (n_fail == 0)
            $display("PASS cd_changer_bus_responder_core");
        else
            $display("FAIL cd_changer_bus_responder_core");
        $finish;
    end

endmodule
